// ===== sv/sdd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the word layout table of the Steim difference decoder.
package sdd_pkg;

    localparam int unsigned FRAME_WORDS = 16;
    localparam int unsigned POS_W       = $clog2(FRAME_WORDS);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_WORDS - 1);

    localparam logic [1:0] LEVEL_STEIM1 = 2'd1;
    localparam logic [1:0] LEVEL_RESET  = 2'd2;

    // Two-bit codes of the control word and sub-codes in the top of a data word.
    localparam logic [1:0] CODE_NONE  = 2'd0;
    localparam logic [1:0] CODE_BYTES = 2'd1;
    localparam logic [1:0] CODE_TWO   = 2'd2;
    localparam logic [1:0] CODE_THREE = 2'd3;
    localparam logic [1:0] SUB_0 = 2'd0;
    localparam logic [1:0] SUB_1 = 2'd1;
    localparam logic [1:0] SUB_2 = 2'd2;
    localparam logic [1:0] SUB_3 = 2'd3;

    // count: differences in the word, width: bits each, lead: unused bits above them.
    typedef struct packed {
        logic [2:0] count;
        logic [5:0] width;
        logic [5:0] lead;
    } t_layout;

    localparam t_layout LAYOUT_NONE = '{count: 3'd0, width: 6'd0, lead: 6'd0};
    localparam t_layout LAYOUT_SEED = '{count: 3'd1, width: 6'd32, lead: 6'd0};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic skip;
        logic emit;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic skip_pend;
        logic out_free;
        logic last;
    } t_status;

    function automatic t_layout layout_of(input logic [1:0] level, input logic [1:0] code,
                                          input logic [1:0] sub);
        t_layout l;
        l = LAYOUT_NONE;
        if (code == CODE_BYTES) begin
            l = '{count: 3'd4, width: 6'd8, lead: 6'd0};
        end else if (level == LEVEL_STEIM1) begin
            case (code)
                CODE_TWO:   l = '{count: 3'd2, width: 6'd16, lead: 6'd0};
                CODE_THREE: l = '{count: 3'd1, width: 6'd32, lead: 6'd0};
                default:    l = LAYOUT_NONE;
            endcase
        end else if (code == CODE_TWO) begin
            case (sub)
                SUB_1:   l = '{count: 3'd1, width: 6'd30, lead: 6'd2};
                SUB_2:   l = '{count: 3'd2, width: 6'd15, lead: 6'd2};
                SUB_3:   l = '{count: 3'd3, width: 6'd10, lead: 6'd2};
                default: l = LAYOUT_NONE;
            endcase
        end else if (code == CODE_THREE) begin
            case (sub)
                SUB_0:   l = '{count: 3'd5, width: 6'd6, lead: 6'd2};
                SUB_1:   l = '{count: 3'd6, width: 6'd5, lead: 6'd2};
                SUB_2:   l = '{count: 3'd7, width: 6'd4, lead: 6'd4};
                default: l = LAYOUT_NONE;
            endcase
        end
        return l;
    endfunction

endpackage

// ===== sv/sdd_if.sv =====
`timescale 1ns / 1ps
// Request channel interfaces for the data words in and the decoded results out.
interface sdd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic        record_start;
    logic [15:0] expected_samples;
    logic        last_word;

    modport source (output valid, data_word, record_start, expected_samples, last_word,
                    input ready);
    modport sink (input valid, data_word, record_start, expected_samples, last_word,
                  output ready);
endinterface

interface sdd_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample;
    logic               record_end;
    logic               record_ok;
    logic               last_of_item;

    modport source (output valid, sample, record_end, record_ok, last_of_item,
                    input ready);
    modport sink (input valid, sample, record_end, record_ok, last_of_item,
                  output ready);
endinterface

// ===== sv/sdd_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer that steps the datapath through the differences of one word.
module sdd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  sdd_pkg::t_status i_status,
    output sdd_pkg::t_cmd    o_cmd
);

    sdd_pkg::t_state r_state;
    sdd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            sdd_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = sdd_pkg::ST_RUN;
                end
            end
            sdd_pkg::ST_RUN: begin
                if (i_status.done) begin
                    n_state = i_status.last ? sdd_pkg::ST_FIN : sdd_pkg::ST_IDLE;
                end else if (i_status.skip_pend) begin
                    o_cmd.skip = 1'b1;
                end else if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                end
            end
            sdd_pkg::ST_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = sdd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sdd_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_result_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit || o_cmd.fin) |-> i_status.out_free)
        else $error("result written while the output register is still full");
    a_no_load_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != sdd_pkg::ST_IDLE) |-> !o_cmd.load)
        else $error("word loaded while the previous word is in progress");
    a_fin_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin |-> i_status.last)
        else $error("end result on a word that is not the last");
`endif

endmodule

// ===== sv/sdd_dp.sv =====
`timescale 1ns / 1ps
// Datapath: frame state, difference extraction, running sum and the output register.
module sdd_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_data,
    input  logic [31:0]       i_data_word,
    input  logic              i_record_start,
    input  logic [15:0]       i_expected_samples,
    input  logic              i_last_word,
    input  sdd_pkg::t_cmd     i_cmd,
    output sdd_pkg::t_status  o_status,
    sdd_out_if.source         o_out
);

    logic [1:0]               r_level;
    logic [sdd_pkg::POS_W-1:0] r_pos;
    logic                     r_first;
    logic [31:0]              r_ctrl;
    logic [31:0]              r_run;
    logic [15:0]              r_emitted;
    logic [15:0]              r_target;
    logic                     r_skip;
    logic [31:0]              r_shreg;
    sdd_pkg::t_layout         r_lay;
    logic [2:0]               r_idx;
    logic                     r_seed;
    logic                     r_last;
    logic                     r_out_valid;
    logic [31:0]              r_out_sample;
    logic                     r_out_end;
    logic                     r_out_ok;
    logic                     r_out_lastof;

    logic [sdd_pkg::POS_W-1:0] pos_eff;
    logic                     first_eff;
    logic                     is_ctrl;
    logic                     is_seed;
    logic                     is_unused;
    logic [5:0]               code_shamt;
    logic [31:0]              ctrl_sh;
    sdd_pkg::t_layout         lay;
    logic signed [31:0]       field;
    logic [31:0]              sum;
    logic                     more;
    logic                     out_free;

    // Decode of the word being accepted.
    always_comb begin
        pos_eff    = i_record_start ? '0 : r_pos;
        first_eff  = i_record_start | r_first;
        is_ctrl    = (pos_eff == '0);
        is_seed    = first_eff && (pos_eff == sdd_pkg::POS_W'(1));
        is_unused  = first_eff && (pos_eff == sdd_pkg::POS_W'(2));
        // The code for word k sits at bits 33-2k and 32-2k of the control word.
        code_shamt = 6'd32 - {1'b0, pos_eff, 1'b0};
        ctrl_sh    = r_ctrl >> code_shamt;
        if (is_ctrl || is_unused) begin
            lay = sdd_pkg::LAYOUT_NONE;
        end else if (is_seed) begin
            lay = sdd_pkg::LAYOUT_SEED;
        end else begin
            lay = sdd_pkg::layout_of(r_level, ctrl_sh[1:0], i_data_word[31:30]);
        end
    end

    // The next difference always sits at the top of the shift register.
    always_comb begin
        field    = $signed(r_shreg) >>> (6'd32 - r_lay.width);
        sum      = r_run + (r_seed ? 32'd0 : field);
        more     = (({1'b0, r_idx} + 4'd1) < {1'b0, r_lay.count}) &&
                   ((r_emitted + 16'd1) < r_target);
        out_free = !r_out_valid || o_out.ready;
        o_status.done      = (r_idx >= r_lay.count) || (r_emitted >= r_target);
        o_status.skip_pend = r_skip && !r_seed;
        o_status.out_free  = out_free;
        o_status.last      = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= sdd_pkg::LEVEL_RESET;
            r_pos     <= '0;
            r_first   <= 1'b1;
            r_ctrl    <= '0;
            r_run     <= '0;
            r_emitted <= '0;
            r_target  <= '0;
            r_skip    <= 1'b0;
            r_lay     <= sdd_pkg::LAYOUT_NONE;
            r_idx     <= '0;
            r_seed    <= 1'b0;
            r_last    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_level <= i_cfg_data;
            end
            if (i_cmd.load) begin
                if (is_ctrl) begin
                    r_ctrl <= i_data_word;
                end
                if (is_seed) begin
                    r_run <= i_data_word;
                end else if (i_record_start) begin
                    r_run <= '0;
                end
                if (i_record_start) begin
                    r_emitted <= '0;
                    r_target  <= i_expected_samples;
                    r_skip    <= 1'b1;
                end
                if (pos_eff == sdd_pkg::POS_LAST) begin
                    r_pos   <= '0;
                    r_first <= 1'b0;
                end else begin
                    r_pos   <= pos_eff + sdd_pkg::POS_W'(1);
                    r_first <= first_eff;
                end
                r_lay  <= lay;
                r_idx  <= '0;
                r_seed <= is_seed;
                r_last <= i_last_word;
            end
            if (i_cmd.skip) begin
                r_skip <= 1'b0;
                r_idx  <= r_idx + 3'd1;
            end
            if (i_cmd.emit) begin
                r_run     <= sum;
                r_idx     <= r_idx + 3'd1;
                r_emitted <= r_emitted + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_shreg <= i_data_word << lay.lead;
        end else if (i_cmd.skip || i_cmd.emit) begin
            r_shreg <= r_shreg << r_lay.width;
        end
    end

    // Output register: a finished result waits here while the next one is prepared.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_sample <= sum;
            r_out_end    <= 1'b0;
            r_out_ok     <= 1'b0;
            r_out_lastof <= !r_last && !more;
        end else if (i_cmd.fin) begin
            r_out_sample <= '0;
            r_out_end    <= 1'b1;
            r_out_ok     <= (r_emitted == r_target);
            r_out_lastof <= 1'b1;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.sample       = r_out_sample;
    assign o_out.record_end   = r_out_end;
    assign o_out.record_ok    = r_out_ok;
    assign o_out.last_of_item = r_out_lastof;

`ifndef SYNTH
    a_count_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emitted <= r_target)
        else $error("more samples emitted than the record holds");
    a_index_in_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_lay.count)
        else $error("difference index ran past the word layout");
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit || i_cmd.fin) |=> r_out_valid)
        else $error("result lost on its way to the output register");
`endif

endmodule

// ===== sv/steim_difference_decoder.sv =====
`timescale 1ns / 1ps
// Top level of the Steim1/Steim2 difference decoder.
// The first result of a taken word passes the sequencer state and then the output register,
// after a skipped first difference when one comes first.
// The differences of a word (up to 7) are handled one per cycle while the output register
// has room; the next word is taken once this one is done, and the last adds an end result.
// A full output register that is not drained stalls the sequence.
// Reset (synchronous, active low) clears frame state, counts and Steim level (to Steim2).
module steim_difference_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_data,
    sdd_in_if.sink     i_in,
    sdd_out_if.source  o_out
);

    sdd_pkg::t_cmd    cmd;
    sdd_pkg::t_status status;
    logic             in_ready;

    assign i_in.ready = in_ready;

    sdd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sdd_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_data_word        (i_in.data_word),
        .i_record_start     (i_in.record_start),
        .i_expected_samples (i_in.expected_samples),
        .i_last_word        (i_in.last_word),
        .i_cmd              (cmd),
        .o_status           (status),
        .o_out              (o_out)
    );

endmodule

// ===== tb/tb_steim_difference_decoder.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the Steim difference decoder with a sample predictor.
module tb_steim_difference_decoder;

    localparam int QUIET_CYCLES = 24;
    localparam longint RUN_LIMIT_NS = 64'd5_000_000;

    localparam int MODE_STEADY       = 0;
    localparam int MODE_SENDER_GAPS  = 1;
    localparam int MODE_SINK_STALLS  = 2;
    localparam int MODE_BOTH_IDLE    = 3;

    typedef struct {
        logic signed [31:0] sample;
        logic               record_end;
        logic               record_ok;
        logic               last_of_item;
    } t_steim_result;

    // Predicts decoded samples per accepted word and checks them in order.
    class sample_ledger;
        logic [1:0]    level;
        logic [3:0]    word_pos;
        bit            first_frame;
        logic [31:0]   control;
        logic [31:0]   running;
        logic [15:0]   emitted;
        logic [15:0]   goal;
        bit            skip_pending;
        t_steim_result pending[$];
        int unsigned   mismatches;
        int unsigned   checked;
        int unsigned   records;
        int unsigned   ends;

        function new();
            level        = sdd_pkg::LEVEL_RESET;
            word_pos     = '0;
            first_frame  = 1'b1;
            control      = '0;
            running      = '0;
            emitted      = '0;
            goal         = '0;
            skip_pending = 1'b0;
            mismatches   = 0;
            checked      = 0;
            records      = 0;
            ends         = 0;
        endfunction

        function void push_sample(input logic [31:0] value, input bit is_end, input bit ok);
            t_steim_result r;
            r.sample       = value;
            r.record_end   = is_end;
            r.record_ok    = ok;
            r.last_of_item = 1'b0;
            pending.insert(pending.size(), r);
        endfunction

        function void note_word(input logic [31:0] w, input bit start, input logic [15:0] count,
                                input bit last);
            int          n;
            int          bits;
            int          p;
            int          made;
            logic [1:0]  code;
            logic [1:0]  sub;
            logic [31:0] mask;
            logic [31:0] diff;
            t_steim_result r;
            made = pending.size();
            if (start) begin
                word_pos     = '0;
                first_frame  = 1'b1;
                running      = '0;
                emitted      = '0;
                goal         = count;
                skip_pending = 1'b1;
                records++;
            end
            p = word_pos;
            if (p == 0) begin
                control = w;
            end else if (first_frame && p == 1) begin
                running = w;
                if (emitted < goal) begin
                    push_sample(running, 1'b0, 1'b0);
                    emitted++;
                end
            end else if (!(first_frame && p == 2)) begin
                code = control[31 - 2 * (p - 1) -: 2];
                sub  = w[31:30];
                n    = 0;
                bits = 0;
                if (code == sdd_pkg::CODE_BYTES) begin
                    n = 4; bits = 8;
                end else if (level == sdd_pkg::LEVEL_STEIM1) begin
                    if (code == sdd_pkg::CODE_TWO) begin
                        n = 2; bits = 16;
                    end else if (code == sdd_pkg::CODE_THREE) begin
                        n = 1; bits = 32;
                    end
                end else if (code == sdd_pkg::CODE_TWO) begin
                    case (sub)
                        sdd_pkg::SUB_1: begin n = 1; bits = 30; end
                        sdd_pkg::SUB_2: begin n = 2; bits = 15; end
                        sdd_pkg::SUB_3: begin n = 3; bits = 10; end
                        default: n = 0;
                    endcase
                end else if (code == sdd_pkg::CODE_THREE) begin
                    case (sub)
                        sdd_pkg::SUB_0: begin n = 5; bits = 6; end
                        sdd_pkg::SUB_1: begin n = 6; bits = 5; end
                        sdd_pkg::SUB_2: begin n = 7; bits = 4; end
                        default: n = 0;
                    endcase
                end
                mask = (bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 32'd1);
                for (int k = 0; k < n; k++) begin
                    if (emitted >= goal) break;
                    // The first difference of a record duplicates the first sample.
                    if (skip_pending) begin
                        skip_pending = 1'b0;
                        continue;
                    end
                    diff = (w >> ((n - 1 - k) * bits)) & mask;
                    if (bits < 32 && diff[bits - 1]) diff = diff | ~mask;
                    running = running + diff;
                    push_sample(running, 1'b0, 1'b0);
                    emitted++;
                end
            end
            if (word_pos == sdd_pkg::POS_LAST) begin
                word_pos    = '0;
                first_frame = 1'b0;
            end else begin
                word_pos = word_pos + 1'b1;
            end
            if (last) push_sample('0, 1'b1, emitted == goal);
            if (pending.size() > made) begin
                r = pending.pop_back();
                r.last_of_item = 1'b1;
                pending.insert(pending.size(), r);
            end
        endfunction

        function void check_result(input logic signed [31:0] sample, input logic record_end,
                                   input logic record_ok, input logic last_of_item);
            t_steim_result e;
            if (pending.size() == 0) begin
                $error("unexpected result: sample %0d record_end %0b", sample, record_end);
                mismatches++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (record_end === 1'b1) ends++;
            if (sample !== e.sample) begin
                $error("sample: expected %0d, actual %0d", e.sample, sample);
                mismatches++;
            end
            if (record_end !== e.record_end) begin
                $error("record_end: expected %0b, actual %0b", e.record_end, record_end);
                mismatches++;
            end
            if (record_ok !== e.record_ok) begin
                $error("record_ok: expected %0b, actual %0b", e.record_ok, record_ok);
                mismatches++;
            end
            if (last_of_item !== e.last_of_item) begin
                $error("last_of_item: expected %0b, actual %0b", e.last_of_item, last_of_item);
                mismatches++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_data;
    logic       sink_ready = 1'b0;
    int         sender_gap_pct = 0;
    int         sink_stall_pct = 0;
    int unsigned words_sent = 0;

    sample_ledger ledger = new();

    sdd_in_if  word_ch ();
    sdd_out_if result_ch ();

    assign result_ch.ready = sink_ready;

    steim_difference_decoder uut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_data(cfg_data),
        .i_in      (word_ch),
        .o_out     (result_ch)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        sink_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n && result_ch.valid && result_ch.ready) begin
            ledger.check_result(result_ch.sample, result_ch.record_end, result_ch.record_ok,
                                result_ch.last_of_item);
        end
    end

    task automatic set_mode(input int mode);
        sender_gap_pct = (mode == MODE_SENDER_GAPS) ? 62 : (mode == MODE_BOTH_IDLE) ? 6 : 0;
        sink_stall_pct = (mode == MODE_SINK_STALLS) ? 62 : (mode == MODE_BOTH_IDLE) ? 6 : 0;
    endtask

    task automatic send_word(input logic [31:0] w, input bit start, input logic [15:0] count,
                             input bit last);
        while ($urandom_range(99) < sender_gap_pct) begin
            word_ch.valid <= 1'b0;
            @(posedge clk);
        end
        word_ch.valid            <= 1'b1;
        word_ch.data_word        <= w;
        word_ch.record_start     <= start;
        word_ch.expected_samples <= count;
        word_ch.last_word        <= last;
        do @(posedge clk); while (word_ch.ready !== 1'b1);
        ledger.note_word(w, start, count, last);
        words_sent++;
    endtask

    // Words that end without a result can leave the block busy, so wait past the drain.
    task automatic settle();
        word_ch.valid <= 1'b0;
        while (ledger.pending.size() != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_level(input logic [1:0] lvl);
        cfg_we   <= 1'b1;
        cfg_data <= lvl;
        @(posedge clk);
        cfg_we <= 1'b0;
        ledger.level = lvl;
    endtask

    // One record in frames: a random control word heads each frame and the data words
    // carry mostly valid sub-codes for the layout the control word selects.
    task automatic send_record(input bit closed);
        int          len;
        logic [15:0] goal;
        logic [31:0] ctrl;
        logic [31:0] w;
        logic [1:0]  code;
        int          p;
        len  = ($urandom_range(3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 20);
        goal = ($urandom_range(5) == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(60));
        ctrl = '0;
        for (int i = 0; i < len; i++) begin
            p = i % sdd_pkg::FRAME_WORDS;
            w = $urandom;
            if (p == 0) begin
                ctrl = w;
            end else if (ledger.level != sdd_pkg::LEVEL_STEIM1) begin
                code = ctrl[31 - 2 * (p - 1) -: 2];
                if (code == sdd_pkg::CODE_TWO) begin
                    w[31:30] = ($urandom_range(9) == 0) ? sdd_pkg::SUB_0
                                                        : 2'($urandom_range(1, 3));
                end else if (code == sdd_pkg::CODE_THREE) begin
                    w[31:30] = ($urandom_range(9) == 0) ? sdd_pkg::SUB_3
                                                        : 2'($urandom_range(0, 2));
                end
            end
            send_word(w, i == 0, (i == 0) ? goal : 16'($urandom), closed && i == len - 1);
        end
    endtask

    task automatic run_phase(input logic [1:0] lvl, input int mode, input int quota);
        int unsigned first;
        int          pick;
        settle();
        write_level(lvl);
        set_mode(mode);
        first = words_sent;
        while (words_sent - first < quota) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                send_record(1'b1);
            end else if (pick < 90) begin
                send_record(1'b0);
            end else begin
                // Stray words that continue or break the current record.
                repeat ($urandom_range(1, 5))
                    send_word($urandom, 1'b0, 16'($urandom), $urandom_range(2) == 0);
            end
        end
    endtask

    initial begin
        rst_n                    <= 1'b0;
        cfg_we                   <= 1'b0;
        cfg_data                 <= sdd_pkg::LEVEL_RESET;
        word_ch.valid            <= 1'b0;
        word_ch.data_word        <= '0;
        word_ch.record_start     <= 1'b0;
        word_ch.expected_samples <= '0;
        word_ch.last_word        <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_mode(MODE_STEADY);

        // Before any record the target is zero, so only end results appear.
        send_word(32'h0000_0000, 1'b0, 16'h0000, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b0, 16'hFFFF, 1'b0);

        // Steim2 record at the reset level covering every layout and both unused sub-codes,
        // ending inside the first frame short of its count.
        send_word(32'h06AB_FC6C, 1'b1, 16'hFFFF, 1'b0);
        send_word(32'h8000_0000, 1'b0, 16'h0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 16'h0000, 1'b0);
        send_word(32'h7F80_01FF, 1'b0, 16'h0000, 1'b0);
        send_word(32'h6000_0000, 1'b0, 16'h0000, 1'b0);
        send_word(32'h9FFF_C000, 1'b0, 16'h0000, 1'b0);
        send_word(32'hDFF8_03FF, 1'b0, 16'h0000, 1'b0);
        send_word(32'h3FFF_FFFF, 1'b0, 16'h0000, 1'b0);
        send_word(32'h1F83_F040, 1'b0, 16'h0000, 1'b0);
        send_word(32'h5F0F_840A, 1'b0, 16'h0000, 1'b0);
        send_word(32'hB78F_01E9, 1'b0, 16'h0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 16'h0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 16'h0000, 1'b0);
        send_word(32'h0102_FE80, 1'b0, 16'h0000, 1'b1);

        // Steim1 record that meets its count exactly, then an empty record.
        settle();
        write_level(sdd_pkg::LEVEL_STEIM1);
        send_word(32'h06C0_0000, 1'b1, 16'd7, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b0, 16'h0000, 1'b0);
        send_word(32'h0000_0000, 1'b0, 16'h0000, 1'b0);
        send_word(32'h0001_807F, 1'b0, 16'h0000, 1'b0);
        send_word(32'h8000_7FFF, 1'b0, 16'h0000, 1'b0);
        send_word(32'h8000_0001, 1'b0, 16'h0000, 1'b0);
        send_word(32'h0000_0000, 1'b0, 16'h0000, 1'b1);
        send_word(32'hA5A5_A5A5, 1'b1, 16'h0000, 1'b1);

        run_phase(2'd1, MODE_STEADY, 12);
        run_phase(2'd2, MODE_SENDER_GAPS, 12);
        run_phase(2'd0, MODE_SINK_STALLS, 12);
        run_phase(2'd3, MODE_BOTH_IDLE, 12);
        run_phase(2'd1, MODE_SENDER_GAPS, 12);
        run_phase(2'd2, MODE_BOTH_IDLE, 12);
        run_phase(2'd1, MODE_SINK_STALLS, 12);
        run_phase(2'd3, MODE_STEADY, 12);
        settle();

        $display("Decoded %0d words over %0d records at Steim levels 0 to 3 under varied idling.",
                 words_sent, ledger.records);
        $display("Checked %0d results, %0d of them record ends.", ledger.checked, ledger.ends);
        if (ledger.mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
sv/sdd_pkg.sv
sv/sdd_if.sv
sv/sdd_ctrl.sv
sv/sdd_dp.sv
sv/steim_difference_decoder.sv
tb/tb_steim_difference_decoder.sv
